[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the text line number filter.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define TXF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true outside reset.
`define TXF_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[hdl/txf_pkg.sv]
// ---------------------------------------------------------------------------
// Text filter package
// Types, character codes and register indexes of the text line number filter.
// ---------------------------------------------------------------------------
`default_nettype none

package txf_pkg;

  // Decimal columns of the line number; a full count of nines saturates.
  localparam int COUNT_DIGITS = 6;
  // Longest run of output bytes for one input byte: number, tab, marker, byte.
  localparam int RUN_MAX      = COUNT_DIGITS + 3;
  localparam int RUN_CNT_W    = $clog2(RUN_MAX + 1);
  localparam int RUN_IDX_W    = $clog2(RUN_MAX);

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 2;

  typedef logic [7:0]                    byte_t;
  typedef logic [COUNT_DIGITS-1:0][3:0]  bcd_t;
  typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]         cfg_data_t;
  typedef logic [1:0]                    num_mode_t;

  // Numbering modes; the unused codes 0 and 3 behave as no numbering.
  localparam num_mode_t NUM_ALL      = 2'd1;
  localparam num_mode_t NUM_NONBLANK = 2'd2;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_NUMBER_MODE      = 3'd0;
  localparam cfg_idx_t CFG_SQUEEZE_BLANK    = 3'd1;
  localparam cfg_idx_t CFG_SHOW_ENDS        = 3'd2;
  localparam cfg_idx_t CFG_SHOW_TABS        = 3'd3;
  localparam cfg_idx_t CFG_SHOW_NONPRINTING = 3'd4;

  // Character codes.
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_NL     = 8'h0A;
  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_DOLLAR = 8'h24;
  localparam byte_t CH_ZERO   = 8'h30;
  localparam byte_t CH_I      = 8'h49;
  localparam byte_t CH_CARET  = 8'h5E;
  localparam byte_t CARET_OFS = 8'd64;

  typedef struct packed {
    num_mode_t number_mode;
    logic      squeeze_blank;
    logic      show_ends;
    logic      show_tabs;
    logic      show_nonprinting;
  } cfg_t;

  // One expanded run: bytes[0] goes out first.
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [RUN_CNT_W-1:0]    count;
  } run_t;

endpackage

`default_nettype wire

[hdl/txf_if.sv]
// ---------------------------------------------------------------------------
// Text filter channels
// Valid/ready interfaces for input bytes, output bytes and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface txf_byte_if import txf_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface txf_res_if import txf_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface txf_cfg_if import txf_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  idx;
  cfg_data_t data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

[hdl/txf_cfg_regs.sv]
// ---------------------------------------------------------------------------
// Text filter configuration registers
// Holds the mode bits; writes to indexes past the last register are dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module txf_cfg_regs import txf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  cfg_idx_t  wr_idx,
  input  cfg_data_t wr_data,
  output cfg_t      cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (wr_idx)
        CFG_NUMBER_MODE:      cfg_r.number_mode      <= wr_data;
        CFG_SQUEEZE_BLANK:    cfg_r.squeeze_blank    <= wr_data[0];
        CFG_SHOW_ENDS:        cfg_r.show_ends        <= wr_data[0];
        CFG_SHOW_TABS:        cfg_r.show_tabs        <= wr_data[0];
        CFG_SHOW_NONPRINTING: cfg_r.show_nonprinting <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[hdl/txf_expand.sv]
// ---------------------------------------------------------------------------
// Text filter byte expander
// Line state and the expansion of one input byte into its output run.
// ---------------------------------------------------------------------------
`default_nettype none

module txf_expand import txf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  advance,
  input  byte_t in_byte,
  input  cfg_t  cfg,
  output run_t  run
);

  // The line count is kept in BCD, least significant digit at index 0.
  logic       prev_nl_r;
  bcd_t       count_r;
  logic [1:0] blank_run_r;

  bcd_t       count_nxt;
  bcd_t       count_inc;
  logic [1:0] blank_run_nxt;
  logic       is_nl;
  logic       drop;
  logic       number;

  always_comb begin
    is_nl         = (in_byte == CH_NL);
    blank_run_nxt = blank_run_r;
    if (cfg.squeeze_blank) begin
      if (is_nl && prev_nl_r) begin
        blank_run_nxt = (blank_run_r == 2'd2) ? 2'd2 : blank_run_r + 2'd1;
      end else begin
        blank_run_nxt = 2'd0;
      end
    end
    drop   = cfg.squeeze_blank && (blank_run_nxt == 2'd2);
    number = !drop && prev_nl_r &&
             ((cfg.number_mode == NUM_ALL) ||
              ((cfg.number_mode == NUM_NONBLANK) && !is_nl));
  end

  // Saturating BCD increment: all nines stays all nines.
  always_comb begin
    logic carry;
    logic all_nines;
    count_inc = count_r;
    carry     = 1'b1;
    all_nines = 1'b1;
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      if (count_r[i] != 4'd9) begin
        all_nines = 1'b0;
      end
    end
    if (!all_nines) begin
      for (int i = 0; i < COUNT_DIGITS; i++) begin
        if (carry) begin
          if (count_r[i] == 4'd9) begin
            count_inc[i] = 4'd0;
          end else begin
            count_inc[i] = count_r[i] + 4'd1;
            carry        = 1'b0;
          end
        end
      end
    end
    count_nxt = number ? count_inc : count_r;
  end

  // Assemble the run: number and tab, then an optional marker, then the byte.
  always_comb begin
    logic                 lead;
    logic [3:0]           digit;
    logic                 mark_en;
    byte_t                mark;
    byte_t                final_byte;
    logic [RUN_IDX_W-1:0] pos;
    run.bytes  = '0;
    lead       = 1'b1;
    digit      = 4'd0;
    mark_en    = 1'b0;
    mark       = CH_CARET;
    final_byte = in_byte;
    pos        = '0;

    if (number) begin
      for (int j = 0; j < COUNT_DIGITS; j++) begin
        digit = count_inc[COUNT_DIGITS-1-j];
        if (digit != 4'd0 || j == COUNT_DIGITS - 1) begin
          lead = 1'b0;
        end
        run.bytes[j] = lead ? CH_SPACE : (CH_ZERO + {4'd0, digit});
      end
      run.bytes[COUNT_DIGITS] = CH_TAB;
      pos = RUN_IDX_W'(COUNT_DIGITS + 1);
    end

    if (cfg.show_tabs && in_byte == CH_TAB) begin
      mark_en    = 1'b1;
      final_byte = CH_I;
    end else if (cfg.show_ends && is_nl) begin
      mark_en    = 1'b1;
      mark       = CH_DOLLAR;
    end else if (cfg.show_nonprinting) begin
      if (in_byte inside {[8'd0:8'd8], [8'd11:8'd31]}) begin
        mark_en    = 1'b1;
        final_byte = in_byte + CARET_OFS;
      end else if (in_byte inside {[8'd127:8'd160]}) begin
        mark_en    = 1'b1;
        final_byte = in_byte - CARET_OFS;
      end
    end

    if (mark_en) begin
      run.bytes[pos] = mark;
      pos            = pos + RUN_IDX_W'(1);
    end
    run.bytes[pos] = final_byte;
    run.count      = drop ? '0 : (RUN_CNT_W'(pos) + RUN_CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_nl_r   <= 1'b1;
      count_r     <= '0;
      blank_run_r <= 2'd0;
    end else if (advance) begin
      prev_nl_r   <= is_nl;
      count_r     <= count_nxt;
      blank_run_r <= blank_run_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/txf_run_buf.sv]
// ---------------------------------------------------------------------------
// Text filter run buffer
// Result register that shifts one expanded run out a byte per beat.
// ---------------------------------------------------------------------------
`default_nettype none

module txf_run_buf import txf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  load,
  input  run_t  run,
  input  logic  out_ready,
  output logic  out_valid,
  output byte_t out_byte,
  output logic  out_last,
  output logic  can_load
);

  logic [RUN_MAX-1:0][7:0] bytes_r;
  logic [RUN_MAX-1:0][7:0] bytes_nxt;
  logic [RUN_CNT_W-1:0]    rem_r;
  logic                    beat;

  always_comb begin
    out_valid = (rem_r != '0);
    out_last  = (rem_r == RUN_CNT_W'(1));
    out_byte  = bytes_r[0];
    beat      = out_valid && out_ready;
    can_load  = !out_valid || (out_last && out_ready);
    for (int i = 0; i < RUN_MAX - 1; i++) begin
      bytes_nxt[i] = bytes_r[i+1];
    end
    bytes_nxt[RUN_MAX-1] = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (load) begin
      rem_r <= run.count;
    end else if (beat) begin
      rem_r <= rem_r - RUN_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= run.bytes;
    end else if (beat) begin
      bytes_r <= bytes_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/text_line_number_filter.sv]
// ---------------------------------------------------------------------------
// Text line number filter
// Byte stream filter: line numbering, blank squeezing and visible markers.
// ---------------------------------------------------------------------------
//
//   Channel   Dir   Payload                  Beat
//   in_ch     in    in_byte[7:0]             one raw text byte
//   out_ch    out   out_byte[7:0], last      one filtered byte, last of its run
//   cfg_ch    in    idx[2:0], data[1:0]      one register write
//
// An input byte is held in the input register and expanded from there
// into the run register, which sends one output byte per beat.
// A byte's whole run occupies the single output byte port, and that port sets
// the sustained input rate.
// Reset is synchronous and active low; the configuration registers read as zero
// and the line state starts as if just after a newline. A stalled output holds
// the run register, and the input register then holds its byte.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module text_line_number_filter import txf_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  txf_byte_if.sink       in_ch,
  txf_res_if.source      out_ch,
  txf_cfg_if.sink        cfg_ch
);

  cfg_t  cfg;
  run_t  run;
  logic  in_valid_r;
  byte_t in_byte_r;
  logic  can_load;
  logic  advance;

  // Register writes are always taken; software is to write only while idle, and the block does not enforce it.
  assign cfg_ch.ready = 1'b1;

  txf_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_idx  (cfg_ch.idx),
    .wr_data (cfg_ch.data),
    .cfg     (cfg)
  );

  // The held byte moves on when the run register is empty or is sending its
  // last byte in this cycle. A squeezed newline moves on with an empty run.
  assign advance     = in_valid_r && can_load;
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.in_byte;
    end
  end

  // Line state and expansion. The state moves only when the byte advances.
  txf_expand u_expand (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .in_byte (in_byte_r),
    .cfg     (cfg),
    .run     (run)
  );

  txf_run_buf u_run_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .run       (run),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last_of_run),
    .can_load  (can_load)
  );

  // Only a squeezed newline may expand to nothing.
  `TXF_ASSERT(a_empty_run_is_nl, clk, rst_n, (advance && run.count == '0) |-> (in_byte_r == CH_NL), "empty run from a byte other than newline")
  // A run never exceeds the longest expansion.
  `TXF_ASSERT_NEVER(a_run_fits, clk, rst_n, advance && (run.count > RUN_CNT_W'(RUN_MAX)), "run longer than the run register")
  // A loaded run shows up on the output in the next cycle.
  `TXF_ASSERT(a_run_shows, clk, rst_n, (advance && run.count != '0) |=> out_ch.valid, "loaded run not presented")
  // After the last beat of a run with nothing loaded behind it, the output idles.
  `TXF_ASSERT(a_last_drains, clk, rst_n, (out_ch.valid && out_ch.ready && out_ch.last_of_run && !advance) |=> !out_ch.valid, "output valid after last beat")

endmodule

`default_nettype wire
